/* rtl/mrpt_pkg.sv */
// Package for the Miller-Rabin prime test block.
// Holds the controller state type and the command and status structs.
// Depends on nothing.
package mrpt_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RED_A,
        ST_POW_BIT,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_CHECK,
        ST_SQ_LOOP,
        ST_SQ_CHK,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_MUL_ACC,
        OP_SQR_BASE,
        OP_SQR_X
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic red_start;
        logic mul_start;
        t_op  op;
        logic shift_exp;
        logic dec_s;
        logic set_x;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic unit_busy;
        logic trivial;
        logic trivial_pass;
        logic exp_zero;
        logic exp_lsb;
        logic x_pass;
        logic x_nm1;
        logic s_left;
    } t_sts;

endpackage

/* rtl/mrpt_modmul.sv */
// Iterative modular multiplier: (x * y) mod m by shift-and-add, one
// multiplier bit per cycle. Uses mrpt_pkg for nothing; stands alone.
module mrpt_modmul #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_busy,
    output logic [WIDTH-1:0] o_res
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;
    logic [WIDTH-1:0] r_m;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [WIDTH:0]   dbl;
    logic [WIDTH:0]   dbl_red;
    logic [WIDTH:0]   add;

    // Double the accumulator, reduce, then add x if the current bit is set.
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, r_m}) ? dbl - {1'b0, r_m} : dbl;
        add     = dbl_red + (r_y[WIDTH-1] ? {1'b0, r_x} : '0);
        n_acc   = (add >= {1'b0, r_m}) ? WIDTH'(add - {1'b0, r_m}) : add[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(WIDTH);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[WIDTH-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy | i_start;
    assign o_res  = r_acc;

endmodule

/* rtl/mrpt_datapath.sv */
// Datapath of the prime test: operand registers, a restoring remainder
// unit for a mod n and the shared modular multiplier. Uses mrpt_pkg.
module mrpt_datapath #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WIDTH-1:0] i_n,
    input  logic [WIDTH-1:0] i_a,
    input  mrpt_pkg::t_cmd   i_cmd,
    output mrpt_pkg::t_sts   o_sts
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_n, r_a, r_d, r_acc, r_base, r_x;
    logic [CW-1:0]    r_s;
    logic [CW-1:0]    r_rcnt;
    logic             r_rbusy;
    logic [WIDTH:0]   r_rem;
    logic [WIDTH-1:0] r_q;
    logic [WIDTH:0]   rem_sh;
    logic [WIDTH-1:0] mx, my;
    logic             mbusy;
    logic [WIDTH-1:0] mres;
    logic [WIDTH-1:0] nm1;
    logic [WIDTH-1:0] nm1_in;
    logic             tz_found;
    logic [CW-1:0]    tz;
    logic [WIDTH-1:0] dsh;

    assign nm1 = r_n - 1'b1;

    // Trailing zero count of n-1, done once per item as a priority search.
    always_comb begin
        nm1_in   = i_n - 1'b1;
        tz       = '0;
        tz_found = 1'b0;
        for (int i = 0; i < WIDTH; i++) begin
            if (!tz_found && nm1_in[i]) begin
                tz       = CW'(i);
                tz_found = 1'b1;
            end
        end
        dsh = nm1_in >> tz;
    end

    // Restoring remainder of a by n, one bit a cycle.
    assign rem_sh = {r_rem[WIDTH-1:0], r_q[WIDTH-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rbusy <= 1'b0;
            r_rcnt  <= '0;
        end else if (i_cmd.red_start) begin
            r_rbusy <= 1'b1;
            r_rcnt  <= CW'(WIDTH);
        end else if (r_rbusy) begin
            r_rcnt  <= r_rcnt - 1'b1;
            r_rbusy <= (r_rcnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.red_start) begin
            r_rem <= '0;
            r_q   <= r_a;
        end else if (r_rbusy) begin
            r_rem <= (rem_sh >= {1'b0, r_n}) ? rem_sh - {1'b0, r_n} : rem_sh;
            r_q   <= {r_q[WIDTH-2:0], 1'b0};
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (i_cmd.op)
            mrpt_pkg::OP_MUL_ACC:  begin mx = r_acc;  my = r_base; end
            mrpt_pkg::OP_SQR_BASE: begin mx = r_base; my = r_base; end
            mrpt_pkg::OP_SQR_X:    begin mx = r_x;    my = r_x;    end
            default:               begin mx = r_acc;  my = r_base; end
        endcase
    end

    mrpt_modmul #(.WIDTH(WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_x     (mx),
        .i_y     (my),
        .i_m     (r_n),
        .o_busy  (mbusy),
        .o_res   (mres)
    );

    // Operand registers, written on controller command.
    logic r_wb_mul;
    mrpt_pkg::t_op r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_mul <= 1'b0;
        end else begin
            r_wb_mul <= mbusy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= i_n;
            r_a   <= i_a;
            r_d   <= dsh;
            r_s   <= tz;
            r_acc <= WIDTH'(1);
        end
        if (i_cmd.mul_start) begin
            r_op <= i_cmd.op;
        end
        if (r_rbusy && r_rcnt == CW'(1)) begin
            r_base <= (rem_sh >= {1'b0, r_n}) ? WIDTH'(rem_sh - {1'b0, r_n})
                                              : rem_sh[WIDTH-1:0];
        end
        if (r_wb_mul && !mbusy) begin
            case (r_op)
                mrpt_pkg::OP_MUL_ACC:  r_acc  <= mres;
                mrpt_pkg::OP_SQR_BASE: r_base <= mres;
                mrpt_pkg::OP_SQR_X:    r_x    <= mres;
                default:               r_acc  <= r_acc;
            endcase
        end
        if (i_cmd.shift_exp) begin
            r_d <= r_d >> 1;
        end
        if (i_cmd.dec_s) begin
            r_s <= r_s - 1'b1;
        end
        if (i_cmd.set_x) begin
            r_x <= r_acc;
        end
    end

    // Status back to the controller. The first check looks at a^d while it
    // is still in the accumulator, in the same cycle that copies it to x.
    always_comb begin
        o_sts.unit_busy    = mbusy | r_rbusy | r_wb_mul | i_cmd.red_start;
        o_sts.trivial      = (r_n < WIDTH'(4)) | ~r_n[0];
        o_sts.trivial_pass = (r_n == WIDTH'(2)) | (r_n == WIDTH'(3));
        o_sts.exp_zero     = (r_d == '0);
        o_sts.exp_lsb      = r_d[0];
        o_sts.x_pass       = (r_acc == WIDTH'(1)) | (r_acc == nm1);
        o_sts.x_nm1        = (r_x == nm1);
        o_sts.s_left       = (r_s > CW'(1));
    end

endmodule

/* rtl/mrpt_ctrl.sv */
// Controller state machine of the prime test: sequences the reduction,
// the square-and-multiply and the final squarings. Uses mrpt_pkg.
module mrpt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_last,
    input  logic           i_out_stall,
    input  mrpt_pkg::t_sts i_sts,
    output logic           o_stall,
    output mrpt_pkg::t_cmd o_cmd,
    output logic           o_valid,
    output logic           o_witness_passed,
    output logic           o_probably_prime,
    output logic           o_final_res
);

    mrpt_pkg::t_state r_state, n_state;
    logic r_verdict, r_last, r_pass, r_valid, r_pp, r_fin, r_wp;
    logic done_now, pass_now;
    logic out_load;

    // The result register takes a new result once it is empty or draining.
    assign out_load = (r_state == mrpt_pkg::ST_DONE) && (!r_valid || !i_out_stall);

    // Next state.
    always_comb begin
        n_state  = r_state;
        done_now = 1'b0;
        pass_now = 1'b0;
        unique case (r_state)
            mrpt_pkg::ST_IDLE:
                if (i_valid) n_state = mrpt_pkg::ST_LOAD;
            mrpt_pkg::ST_LOAD: begin
                if (i_sts.trivial) begin
                    done_now = 1'b1;
                    pass_now = i_sts.trivial_pass;
                end else begin
                    n_state = mrpt_pkg::ST_RED_A;
                end
            end
            mrpt_pkg::ST_RED_A:
                if (!i_sts.unit_busy) n_state = mrpt_pkg::ST_POW_BIT;
            mrpt_pkg::ST_POW_BIT: begin
                if (i_sts.exp_zero) n_state = mrpt_pkg::ST_CHECK;
                else if (i_sts.exp_lsb) n_state = mrpt_pkg::ST_POW_MUL;
                else n_state = mrpt_pkg::ST_POW_SQR;
            end
            mrpt_pkg::ST_POW_MUL:
                if (!i_sts.unit_busy) n_state = mrpt_pkg::ST_POW_SQR;
            mrpt_pkg::ST_POW_SQR:
                if (!i_sts.unit_busy) n_state = mrpt_pkg::ST_POW_BIT;
            mrpt_pkg::ST_CHECK: begin
                if (i_sts.x_pass) begin
                    done_now = 1'b1;
                    pass_now = 1'b1;
                end else if (i_sts.s_left) begin
                    n_state = mrpt_pkg::ST_SQ_LOOP;
                end else begin
                    done_now = 1'b1;
                end
            end
            mrpt_pkg::ST_SQ_LOOP:
                if (!i_sts.unit_busy) n_state = mrpt_pkg::ST_SQ_CHK;
            mrpt_pkg::ST_SQ_CHK: begin
                if (i_sts.x_nm1) begin
                    done_now = 1'b1;
                    pass_now = 1'b1;
                end else if (i_sts.s_left) begin
                    n_state = mrpt_pkg::ST_SQ_LOOP;
                end else begin
                    done_now = 1'b1;
                end
            end
            mrpt_pkg::ST_DONE:
                if (!r_valid || !i_out_stall) n_state = mrpt_pkg::ST_IDLE;
            default: n_state = mrpt_pkg::ST_IDLE;
        endcase
        if (done_now) n_state = mrpt_pkg::ST_DONE;
    end

    // Commands to the datapath; each unit start is a one-cycle pulse.
    logic r_started;
    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = mrpt_pkg::OP_NONE;
        o_cmd.load      = (r_state == mrpt_pkg::ST_IDLE) && i_valid;
        unique case (r_state)
            mrpt_pkg::ST_RED_A:   o_cmd.red_start = !r_started;
            mrpt_pkg::ST_POW_MUL: begin
                o_cmd.op        = mrpt_pkg::OP_MUL_ACC;
                o_cmd.mul_start = !r_started;
            end
            mrpt_pkg::ST_POW_SQR: begin
                o_cmd.op        = mrpt_pkg::OP_SQR_BASE;
                o_cmd.mul_start = !r_started;
                o_cmd.shift_exp = r_started && !i_sts.unit_busy;
            end
            mrpt_pkg::ST_CHECK:   o_cmd.set_x = 1'b1;
            mrpt_pkg::ST_SQ_LOOP: begin
                o_cmd.op        = mrpt_pkg::OP_SQR_X;
                o_cmd.mul_start = !r_started;
                o_cmd.dec_s     = r_started && !i_sts.unit_busy;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mrpt_pkg::ST_IDLE;
            r_started <= 1'b0;
            r_verdict <= 1'b1;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= (n_state == r_state) && (r_state != mrpt_pkg::ST_IDLE);
            if (out_load) begin
                r_valid   <= 1'b1;
                r_verdict <= r_last ? 1'b1 : (r_verdict & r_pass);
            end else if (!i_out_stall) begin
                r_valid   <= 1'b0;
            end
        end
    end

    // Result register; it holds its fields while the transfer is stalled.
    always_ff @(posedge i_clk) begin
        if (o_cmd.load) r_last <= i_last;
        if (done_now) r_pass <= pass_now;
        if (out_load) begin
            r_wp  <= r_pass;
            r_pp  <= r_verdict & r_pass;
            r_fin <= r_last;
        end
    end

    assign o_stall          = (r_state != mrpt_pkg::ST_IDLE);
    assign o_valid          = r_valid;
    assign o_witness_passed = r_wp;
    assign o_probably_prime = r_pp;
    assign o_final_res      = r_fin;

endmodule

/* rtl/miller_rabin_prime_test.sv */
// Miller-Rabin witness test, one witness per transfer, with a running
// verdict per candidate. Every modular multiplication runs in the shared
// shift-and-add unit, a is first reduced mod n in the remainder unit, and
// a^d mod n needs up to two multiplications per exponent bit plus the final
// squarings. Trivial candidates (below 4 or even) skip the arithmetic. One
// item is in work at a time; the result register lets the next item enter
// while a result waits.
module miller_rabin_prime_test #(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_candidate,
    input  logic [31:0] i_witness,
    input  logic        i_last_witness,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_witness_passed,
    output logic        o_probably_prime,
    output logic        o_final_res
);

    mrpt_pkg::t_cmd cmd;
    mrpt_pkg::t_sts sts;

    mrpt_datapath #(.WIDTH(WIDTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_n     (i_candidate[WIDTH-1:0]),
        .i_a     (i_witness[WIDTH-1:0]),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

    mrpt_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_last           (i_last_witness),
        .i_out_stall      (i_stall),
        .i_sts            (sts),
        .o_stall          (o_stall),
        .o_cmd            (cmd),
        .o_valid          (o_valid),
        .o_witness_passed (o_witness_passed),
        .o_probably_prime (o_probably_prime),
        .o_final_res      (o_final_res)
    );

endmodule

/* test/miller_rabin_prime_test_checker.sv */
// Checker for the Miller-Rabin prime test block: watches both channels,
// predicts each result from the accepted transfers and compares them.
// Depends on nothing but the port list of miller_rabin_prime_test.
module miller_rabin_prime_test_checker #(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_dut_stall,
    input  logic [31:0] i_candidate,
    input  logic [31:0] i_witness,
    input  logic        i_last_witness,
    input  logic        i_dut_valid,
    input  logic        i_stall,
    input  logic        i_witness_passed,
    input  logic        i_probably_prime,
    input  logic        i_final_res,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_primes
);

    typedef struct packed {
        logic passed;
        logic prime;
        logic final_mark;
    } t_verdict;

    t_verdict   verdict_q[$];
    logic       all_passed;

    // Modular product; both operands are below m, so the product fits in 64 bits.
    function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y,
                                            logic [63:0] m);
        return (x * y) % m;
    endfunction

    // One witness round for candidate n and base a.
    function automatic logic witness_holds(logic [63:0] n, logic [63:0] a);
        logic [63:0] d;
        logic [63:0] x;
        logic [63:0] b;
        int          s;
        if (n < 2) return 1'b0;
        if (n == 2 || n == 3) return 1'b1;
        if (n[0] == 1'b0) return 1'b0;
        d = n - 1;
        s = 0;
        while (d[0] == 1'b0) begin
            d = d >> 1;
            s++;
        end
        b = a % n;
        x = 1;
        while (d != 0) begin
            if (d[0]) x = mul_mod(x, b, n);
            b = mul_mod(b, b, n);
            d = d >> 1;
        end
        if (x == 1 || x == n - 1) return 1'b1;
        for (int i = 1; i < s; i++) begin
            x = mul_mod(x, x, n);
            if (x == n - 1) return 1'b1;
        end
        return 1'b0;
    endfunction

    assign o_pending = verdict_q.size();

    // Predict on accepted input transfers, compare on accepted output transfers.
    always @(posedge i_clk) begin
        t_verdict    exp_v;
        t_verdict    got_v;
        logic [63:0] mask;
        mask = (64'd1 << WIDTH) - 1;
        if (!i_rst_n) begin
            all_passed = 1'b1;
            verdict_q.delete();
            o_errors  <= 0;
            o_results <= 0;
            o_primes  <= 0;
        end else begin
            if (i_valid && !i_dut_stall) begin
                exp_v.passed     = witness_holds({32'd0, i_candidate} & mask,
                                                 {32'd0, i_witness} & mask);
                exp_v.prime      = all_passed & exp_v.passed;
                exp_v.final_mark = i_last_witness;
                all_passed       = i_last_witness ? 1'b1 : exp_v.prime;
                verdict_q.push_back(exp_v);
            end
            if (i_dut_valid && !i_stall) begin
                got_v = '{i_witness_passed, i_probably_prime, i_final_res};
                o_results <= o_results + 1;
                if (verdict_q.size() == 0) begin
                    $display("%0t: result %b with nothing expected", $time, got_v);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (got_v.final_mark && got_v.prime) o_primes <= o_primes + 1;
                    if (got_v !== exp_v) begin
                        $display("%0t: mismatch passed/prime/final expected %b actual %b",
                                 $time, exp_v, got_v);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* test/miller_rabin_prime_test_test.sv */
// Testbench top for the Miller-Rabin prime test block: drives witness
// transfers, stalls the result side and gives the verdict.
// Depends on miller_rabin_prime_test and miller_rabin_prime_test_checker.
module miller_rabin_prime_test_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_candidate;
    logic [31:0] i_witness;
    logic        i_last_witness;
    logic        o_valid;
    logic        i_stall;
    logic        o_witness_passed;
    logic        o_probably_prime;
    logic        o_final_res;
    int          errors;
    int          pending;
    int          results;
    int          primes;
    logic        calm;

    // Known primes and composites, among them strong pseudoprimes to base 2.
    logic [31:0] primes_tab[8] = '{32'd5, 32'd7, 32'd13, 32'd97, 32'd65537,
                                   32'd2147483647, 32'd4294967291, 32'd1000003};
    logic [31:0] comps_tab[8]  = '{32'd9, 32'd15, 32'd2047, 32'd3277, 32'd561,
                                   32'd4294967295, 32'd25326001, 32'd3215031751};

    miller_rabin_prime_test u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_candidate, .i_witness,
        .i_last_witness, .o_valid, .i_stall, .o_witness_passed,
        .o_probably_prime, .o_final_res
    );

    miller_rabin_prime_test_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_dut_stall(o_stall), .i_candidate,
        .i_witness, .i_last_witness, .i_dut_valid(o_valid), .i_stall,
        .i_witness_passed(o_witness_passed), .i_probably_prime(o_probably_prime),
        .i_final_res(o_final_res), .o_errors(errors), .o_pending(pending),
        .o_results(results), .o_primes(primes)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Result-side stall, quiet while calm is set.
    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 26);
    end

    // Offer one witness transfer and hold it until it is accepted; the
    // caller drops valid once no further transfer follows.
    task automatic send_witness(logic [31:0] n, logic [31:0] a, logic last);
        while (!calm && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_candidate    <= n;
        i_witness      <= a;
        i_last_witness <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // A full test of one candidate: one to four random witnesses, the last marked.
    task automatic test_candidate(logic [31:0] n);
        int k;
        k = $urandom_range(4, 1);
        for (int i = 0; i < k; i++) send_witness(n, $urandom, i == k - 1);
    endtask

    initial begin
        logic [31:0] n;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_candidate    = '0;
        i_witness      = '0;
        i_last_witness = 1'b0;
        calm           = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: small and even candidates, degenerate witnesses, extremes.
        send_witness(32'd0, 32'd3, 1'b1);
        send_witness(32'd1, 32'd0, 1'b1);
        send_witness(32'd2, 32'd0, 1'b1);
        send_witness(32'd3, 32'hFFFF_FFFF, 1'b1);
        send_witness(32'd4, 32'd1, 1'b1);
        send_witness(32'hFFFF_FFFE, 32'd3, 1'b1);
        send_witness(32'd7, 32'd14, 1'b1);
        send_witness(32'd7, 32'd6, 1'b0);
        send_witness(32'd7, 32'd1, 1'b1);
        send_witness(32'd2047, 32'd2, 1'b0);
        send_witness(32'd2047, 32'd3, 1'b1);
        send_witness(32'd4294967291, 32'hFFFF_FFFF, 1'b1);
        send_witness(32'hFFFF_FFFF, 32'd2, 1'b1);
        // Verdict carried across a candidate change without the last mark.
        send_witness(32'd9, 32'd2, 1'b0);
        send_witness(32'd13, 32'd2, 1'b1);
        send_witness(32'd2147483647, 32'd12345, 1'b1);
        i_valid <= 1'b0;

        // Hold off until every expected result has come back.
        wait (pending == 0);
        @(negedge i_clk);

        // Random: mostly whole candidate tests, with one calm stretch.
        for (int c = 0; c < 52; c++) begin
            calm = (c >= 20 && c < 30);
            case ($urandom_range(5))
                0, 1:    n = primes_tab[$urandom_range(7)];
                2:       n = comps_tab[$urandom_range(7)];
                3:       n = $urandom_range(40);
                default: n = $urandom | (($urandom_range(3) == 0) ? 32'd0 : 32'd1);
            endcase
            if ($urandom_range(9) == 0) send_witness(n, $urandom, 1'($urandom_range(1)));
            else test_candidate(n);
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        $display("Covered %0d results, %0d candidates reported probably prime.",
                 results, primes);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: ends the run with an error if it has not finished in time.
    initial begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
